### design/gtww_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the greedy word wrap core.
// Used by gtww_step, gtww_queue and greedy_text_word_wrap_core; no dependencies.
package gtww_pkg;

   localparam int COLUMN_BITS  = 16;
   localparam int WIDTH_BITS   = 16;
   localparam int BYTE_BITS    = 8;
   localparam int MAX_RESULTS  = 4;
   localparam int COUNT_BITS   = $clog2(MAX_RESULTS + 1);
   localparam int QUEUE_DEPTH  = 2 * MAX_RESULTS;
   localparam int PTR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int FILL_BITS    = $clog2(QUEUE_DEPTH + 1);
   localparam int CMP_BITS     = (COLUMN_BITS > WIDTH_BITS) ? COLUMN_BITS : WIDTH_BITS;

   localparam logic [WIDTH_BITS-1:0] DEFAULT_WIDTH = WIDTH_BITS'(75);
   localparam logic [BYTE_BITS-1:0]  CHAR_NL       = 8'd10;
   localparam logic [BYTE_BITS-1:0]  CHAR_SP       = 8'd32;
   localparam logic [BYTE_BITS-1:0]  CHAR_TAB      = 8'd9;
   localparam logic [BYTE_BITS-1:0]  CHAR_CR       = 8'd13;

   typedef struct packed {
      logic [COLUMN_BITS-1:0] column;
      logic                   in_word;
      logic                   newline_pending;
   } wrap_state_type;

   typedef struct packed {
      logic [BYTE_BITS-1:0] out_byte;
      logic                 run_last;
   } result_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0]             count;
      result_type [MAX_RESULTS-1:0]      entry;
   } push_type;

endpackage

### design/gtww_step.sv
`timescale 1ns / 1ps
// Combinational step of the word wrap: one registered byte and the current state
// give up to four result bytes and the next state. Depends on gtww_pkg.
module gtww_step (
   input  logic [gtww_pkg::BYTE_BITS-1:0]  text_byte,
   input  logic                            file_end,
   input  logic                            stream_end,
   input  logic [gtww_pkg::WIDTH_BITS-1:0] line_width,
   input  gtww_pkg::wrap_state_type        state_cur,
   output gtww_pkg::wrap_state_type        state_next,
   output gtww_pkg::push_type              push
);
   import gtww_pkg::*;

   function automatic logic [COLUMN_BITS-1:0] bump(input logic [COLUMN_BITS-1:0] col);
      logic [COLUMN_BITS-1:0] result;
      result = (col == '1) ? col : col + COLUMN_BITS'(1);
      return result;
   endfunction

   logic is_nl;
   logic is_blank;
   logic any_end;

   assign is_nl    = (text_byte == CHAR_NL);
   assign is_blank = (text_byte == CHAR_SP) ||
                     ((text_byte >= CHAR_TAB) && (text_byte <= CHAR_CR));
   assign any_end  = file_end || stream_end;

   always_comb begin
      wrap_state_type               st;
      result_type [MAX_RESULTS-1:0] res;
      logic [COUNT_BITS-1:0]        n;
      logic [COUNT_BITS-1:0]        last_idx;
      logic                         handled;

      st       = state_cur;
      res      = '0;
      n        = '0;
      handled  = 1'b0;
      last_idx = '0;

      if (st.newline_pending) begin
         st.newline_pending = 1'b0;
         if (is_nl) begin
            res[n[1:0]].out_byte = CHAR_NL;
            n = n + COUNT_BITS'(1);
            res[n[1:0]].out_byte = CHAR_NL;
            n = n + COUNT_BITS'(1);
            st.column  = '0;
            st.in_word = 1'b0;
            handled    = 1'b1;
         end else if (st.in_word) begin
            res[n[1:0]].out_byte = CHAR_SP;
            n = n + COUNT_BITS'(1);
            st.column  = bump(st.column);
            st.in_word = 1'b0;
         end
      end

      if (!handled) begin
         if (is_nl && !any_end) begin
            st.newline_pending = 1'b1;
         end else if (is_nl || is_blank) begin
            if (st.in_word) begin
               res[n[1:0]].out_byte = CHAR_SP;
               n = n + COUNT_BITS'(1);
               st.column  = bump(st.column);
               st.in_word = 1'b0;
            end
         end else begin
            if (!st.in_word &&
                (CMP_BITS'(st.column) >= CMP_BITS'(line_width))) begin
               res[n[1:0]].out_byte = CHAR_NL;
               n = n + COUNT_BITS'(1);
               st.column = '0;
            end
            res[n[1:0]].out_byte = text_byte;
            n = n + COUNT_BITS'(1);
            st.column  = bump(st.column);
            st.in_word = 1'b1;
         end
      end

      if (stream_end) begin
         if (st.column != '0) begin
            res[n[1:0]].out_byte = CHAR_NL;
            n = n + COUNT_BITS'(1);
         end
         st = '0;
      end

      if (n != '0) begin
         last_idx = n - COUNT_BITS'(1);
         res[last_idx[1:0]].run_last = 1'b1;
      end

      state_next  = st;
      push.count  = n;
      push.entry  = res;
   end

endmodule

### design/gtww_queue.sv
`timescale 1ns / 1ps
// Output queue of result bytes: takes up to four per cycle, gives one per cycle while rsp_ready is high.
// Depends on gtww_pkg.
module gtww_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push_en,
   input  gtww_pkg::push_type              push,
   output logic                            has_room,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [gtww_pkg::BYTE_BITS-1:0]  rsp_out_byte,
   output logic                            rsp_run_last
);
   import gtww_pkg::*;

   result_type            mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FILL_BITS-1:0]  fill_ff, fill_in;
   logic [FILL_BITS-1:0]  push_n;
   logic                  pop;

   assign pop          = rsp_valid && rsp_ready;
   assign push_n       = push_en ? FILL_BITS'(push.count) : '0;
   assign rsp_valid    = (fill_ff != '0);
   assign rsp_out_byte = mem_ff[rd_ptr_ff].out_byte;
   assign rsp_run_last = mem_ff[rd_ptr_ff].run_last;
   assign has_room     = (fill_ff <= FILL_BITS'(QUEUE_DEPTH - MAX_RESULTS));

   assign wr_ptr_in = wr_ptr_ff + PTR_BITS'(push_n);
   assign rd_ptr_in = rd_ptr_ff + PTR_BITS'(pop);
   assign fill_in   = fill_ff + push_n - FILL_BITS'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
         if (push_en && (COUNT_BITS'(k) < push.count)) begin
            mem_ff[wr_ptr_ff + PTR_BITS'(k)] <= push.entry[k];
         end
      end
   end

endmodule

### design/greedy_text_word_wrap_core.sv
`timescale 1ns / 1ps
// The core takes one text byte per request and returns the reflowed bytes, one per
// response, with run_last marking the final byte a request caused. A request is
// registered on entry and processed once the output queue has room for it; its results
// leave through that queue. Requests flow at one per cycle as long as each yields
// at most one byte on average; the eight-entry output queue must hold room for four
// bytes before a request is processed, so requests that expand into several bytes,
// or a stalled response side, hold off new requests. The line width register may be
// written only while the core is idle.
// Depends on gtww_pkg, gtww_step and gtww_queue.
module greedy_text_word_wrap_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [gtww_pkg::WIDTH_BITS-1:0]  csr_wr_data,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [gtww_pkg::BYTE_BITS-1:0]   req_text_byte,
   input  logic                             req_file_end,
   input  logic                             req_stream_end,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [gtww_pkg::BYTE_BITS-1:0]   rsp_out_byte,
   output logic                             rsp_run_last
);
   import gtww_pkg::*;

   logic [WIDTH_BITS-1:0] line_width_ff;
   wrap_state_type        state_ff, state_in;
   logic                  in_valid_ff, in_valid_in;
   logic [BYTE_BITS-1:0]  in_byte_ff;
   logic                  in_file_end_ff;
   logic                  in_stream_end_ff;
   push_type              push;
   logic                  has_room;
   logic                  fire;
   logic                  accept;

   assign fire        = in_valid_ff && has_room;
   assign req_ready   = !in_valid_ff || fire;
   assign accept      = req_valid && req_ready;
   assign in_valid_in = accept || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= DEFAULT_WIDTH;
         state_ff      <= '0;
         in_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            line_width_ff <= csr_wr_data;
         end
         if (fire) begin
            state_ff <= state_in;
         end
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff       <= req_text_byte;
         in_file_end_ff   <= req_file_end;
         in_stream_end_ff <= req_stream_end;
      end
   end

   gtww_step u_step (
      .text_byte  (in_byte_ff),
      .file_end   (in_file_end_ff),
      .stream_end (in_stream_end_ff),
      .line_width (line_width_ff),
      .state_cur  (state_ff),
      .state_next (state_in),
      .push       (push)
   );

   gtww_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push_en      (fire),
      .push         (push),
      .has_room     (has_room),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_last (rsp_run_last)
   );

endmodule

### bench/tb_greedy_text_word_wrap_core.sv
`timescale 1ns / 1ps
// Testbench for greedy_text_word_wrap_core: drives text bytes, predicts the reflowed
// output with its own word wrap model and checks every response byte in order.
// Depends on gtww_pkg and the greedy_text_word_wrap_core RTL.
module tb_greedy_text_word_wrap_core;
   import gtww_pkg::*;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [WIDTH_BITS-1:0]  csr_wr_data = '0;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [BYTE_BITS-1:0]   req_text_byte = '0;
   logic                   req_file_end = 1'b0;
   logic                   req_stream_end = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [BYTE_BITS-1:0]   rsp_out_byte;
   logic                   rsp_run_last;

   logic [COLUMN_BITS-1:0] wrap_column;
   logic [WIDTH_BITS-1:0]  wrap_width;
   logic                   wrap_in_word;
   logic                   wrap_nl_pending;
   result_type             step_bytes[$];
   result_type             reflow_queue[$];
   result_type             reflow_head;
   int                     mismatch_count = 0;
   int                     items_sent = 0;
   bit                     req_idle_on = 1'b1;
   bit                     rsp_idle_on = 1'b1;

   greedy_text_word_wrap_core uut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_text_byte  (req_text_byte),
      .req_file_end   (req_file_end),
      .req_stream_end (req_stream_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic bit is_blank(input logic [BYTE_BITS-1:0] c);
      return c == CHAR_SP || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   function automatic void note_byte(input logic [BYTE_BITS-1:0] c);
      result_type r;
      r.out_byte = c;
      r.run_last = 1'b0;
      step_bytes.push_back(r);
   endfunction

   function automatic void bump_column();
      if (wrap_column != '1) begin
         wrap_column = wrap_column + 1'b1;
      end
   endfunction

   function automatic void close_word();
      if (wrap_in_word) begin
         note_byte(CHAR_SP);
         bump_column();
         wrap_in_word = 1'b0;
      end
   endfunction

   function automatic void wrap_predict(input logic [BYTE_BITS-1:0] c, input logic fe_in,
                                        input logic se);
      logic fe;
      logic handled;
      fe = fe_in | se;
      handled = 1'b0;
      step_bytes.delete();
      if (wrap_nl_pending) begin
         wrap_nl_pending = 1'b0;
         if (c == CHAR_NL) begin
            note_byte(CHAR_NL);
            note_byte(CHAR_NL);
            wrap_column = '0;
            wrap_in_word = 1'b0;
            handled = 1'b1;
         end else begin
            close_word();
         end
      end
      if (!handled) begin
         if (c == CHAR_NL) begin
            if (fe) begin
               close_word();
            end else begin
               wrap_nl_pending = 1'b1;
            end
         end else if (is_blank(c)) begin
            close_word();
         end else begin
            if (!wrap_in_word && wrap_column >= wrap_width) begin
               note_byte(CHAR_NL);
               wrap_column = '0;
            end
            note_byte(c);
            bump_column();
            wrap_in_word = 1'b1;
         end
      end
      if (se) begin
         if (wrap_column != '0) begin
            note_byte(CHAR_NL);
         end
         wrap_column = '0;
         wrap_in_word = 1'b0;
         wrap_nl_pending = 1'b0;
      end
      if (step_bytes.size() > 0) begin
         step_bytes[step_bytes.size() - 1].run_last = 1'b1;
      end
      foreach (step_bytes[i]) begin
         reflow_queue.push_back(step_bytes[i]);
      end
   endfunction

   task automatic send_byte(input logic [BYTE_BITS-1:0] c, input logic fe = 1'b0,
                            input logic se = 1'b0);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 12) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_text_byte  <= c;
      req_file_end   <= fe;
      req_stream_end <= se;
      do @(posedge clock); while (!req_ready);
      wrap_predict(c, fe, se);
      items_sent++;
   endtask

   task automatic drain_outputs();
      @(negedge clock);
      req_valid <= 1'b0;
      while (reflow_queue.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_width(input logic [WIDTH_BITS-1:0] w);
      drain_outputs();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= w;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      wrap_width = w;
   endtask

   function automatic logic [BYTE_BITS-1:0] pick_blank();
      unique case ($urandom_range(0, 4))
         0: return CHAR_TAB;
         1: return CHAR_CR;
         2: return 8'd11;
         3: return 8'd12;
         default: return CHAR_SP;
      endcase
   endfunction

   function automatic logic [BYTE_BITS-1:0] pick_word_char();
      logic [BYTE_BITS-1:0] c;
      if ($urandom_range(0, 99) < 85) begin
         return 8'(8'd97 + $urandom_range(0, 25));
      end
      do c = 8'($urandom_range(0, 255)); while (is_blank(c));
      return c;
   endfunction

   task automatic test_blank_runs();
      send_byte(8'd65);
      send_byte(8'hFF);
      send_byte(CHAR_SP);
      send_byte(CHAR_TAB);
      send_byte(CHAR_CR);
      send_byte(8'd11);
      send_byte(8'd12);
      send_byte(8'h00);
      send_byte(8'd120);
   endtask

   task automatic test_newline_handling();
      send_byte(CHAR_NL);
      send_byte(8'd119);
      send_byte(CHAR_NL);
      send_byte(CHAR_NL);
      send_byte(8'd113);
      send_byte(CHAR_NL, 1'b1, 1'b0);
      send_byte(8'd122, 1'b0, 1'b1);
   endtask

   task automatic test_narrow_lines();
      set_width(16'd1);
      send_byte(8'd97);
      send_byte(8'd98);
      send_byte(CHAR_SP);
      send_byte(8'd99);
      send_byte(CHAR_NL);
      send_byte(CHAR_NL, 1'b0, 1'b1);
   endtask

   task automatic test_wide_lines();
      set_width(16'hFFFF);
      send_byte(8'd97);
      send_byte(CHAR_SP);
      send_byte(8'd98, 1'b0, 1'b1);
   endtask

   task automatic test_random_text();
      int phase_start;
      int word_len;
      int blank_len;
      int pick;
      logic [WIDTH_BITS-1:0] phase_width;
      for (int phase = 0; phase < 6; phase++) begin
         unique case (phase)
            0: phase_width = 16'd1;
            1: phase_width = 16'd4;
            2: phase_width = 16'($urandom_range(2, 40));
            3: phase_width = 16'hFFFF;
            4: phase_width = 16'd12;
            default: phase_width = DEFAULT_WIDTH;
         endcase
         set_width(phase_width);
         phase_start = items_sent;
         while (items_sent - phase_start < 55) begin
            if ($urandom_range(0, 39) == 0) begin
               req_idle_on = ~req_idle_on;
            end
            if ($urandom_range(0, 39) == 0) begin
               rsp_idle_on = ~rsp_idle_on;
            end
            if (phase == 3 && items_sent - phase_start == 27) begin
               drain_outputs();
            end
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               word_len = $urandom_range(1, 8);
               for (int i = 1; i < word_len; i++) begin
                  send_byte(pick_word_char());
               end
               send_byte(pick_word_char(), $urandom_range(0, 9) == 0, 1'b0);
            end else if (pick < 75) begin
               blank_len = $urandom_range(1, 3);
               repeat (blank_len) send_byte(pick_blank());
            end else if (pick < 85) begin
               send_byte(CHAR_NL);
            end else if (pick < 90) begin
               send_byte(CHAR_NL);
               send_byte(CHAR_NL);
            end else if (pick < 97) begin
               send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                         $urandom_range(0, 15) == 0);
            end else begin
               send_byte(CHAR_NL, 1'b1, $urandom_range(0, 1) == 1);
            end
         end
         send_byte(pick_word_char(), 1'b0, 1'b1);
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (reflow_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 40) begin
               $error("unexpected response: out_byte %0d run_last %0d", rsp_out_byte,
                      rsp_run_last);
            end
         end else begin
            reflow_head = reflow_queue.pop_front();
            if (rsp_out_byte !== reflow_head.out_byte) begin
               mismatch_count++;
               if (mismatch_count <= 40) begin
                  $error("out_byte: expected %0d, actual %0d", reflow_head.out_byte,
                         rsp_out_byte);
               end
            end
            if (rsp_run_last !== reflow_head.run_last) begin
               mismatch_count++;
               if (mismatch_count <= 40) begin
                  $error("run_last: expected %0d, actual %0d", reflow_head.run_last,
                         rsp_run_last);
               end
            end
         end
      end
   end

   initial begin
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = rsp_idle_on ? $urandom_range(0, 12) : 0;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin
      wrap_column     = '0;
      wrap_width      = DEFAULT_WIDTH;
      wrap_in_word    = 1'b0;
      wrap_nl_pending = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_blank_runs();
      test_newline_handling();
      test_narrow_lines();
      test_wide_lines();
      test_random_text();
      drain_outputs();
      if (reflow_queue.size() != 0) begin
         $error("%0d expected response bytes never arrived", reflow_queue.size());
      end
      if (mismatch_count == 0 && reflow_queue.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
